// File: hdl/priority_scheduler_with_aging_unit_assert.svh
// Assertion macros used by the scheduler controller RTL.
`ifndef PRIORITY_SCHEDULER_WITH_AGING_UNIT_ASSERT_SVH
`define PRIORITY_SCHEDULER_WITH_AGING_UNIT_ASSERT_SVH

// Checked only outside reset.
`define PSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PSA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/psa_pkg.sv
// Shared constants and types of the priority scheduler.
package psa_pkg;

    localparam int NUM_TASKS = 16;
    localparam int PRIO_BITS = 8;
    localparam int ID_W      = $clog2(NUM_TASKS);
    localparam int PTR_W     = $clog2(NUM_TASKS + 1);
    localparam int SLICE_W   = 8;
    localparam int TASK_W    = 4;
    localparam int OPRIO_W   = 8;
    localparam int IPRIO_W   = 8;
    localparam int AGED_W    = 4;

    localparam logic [PTR_W-1:0]     TAIL_MARK = PTR_W'(NUM_TASKS);
    localparam logic [PRIO_BITS-1:0] KEY_MAX   = {PRIO_BITS{1'b1}};

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_RUN     = 2'd2,
        CMD_BLOCK   = 2'd3
    } psa_cmd_t;

    typedef struct packed {
        logic [PRIO_BITS-1:0] key;
        logic [PTR_W-1:0]     nxt;
    } psa_entry_t;

    localparam int ENTRY_W = $bits(psa_entry_t);

    typedef struct packed {
        logic                  enqueue_rejected;
        logic [AGED_W-1:0]     aged_count;
        logic                  deferred_attempt;
        logic                  switched;
        logic [OPRIO_W-1:0]    running_priority;
        logic [TASK_W-1:0]     running_task;
    } psa_result_t;

endpackage

// File: hdl/psa_ram.sv
// Single write port, single read port memory with a registered read.
module psa_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 13
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/psa_ctrl.sv
// Sequencer that walks the ready list in memory for insert, aging and dequeue.
module psa_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      in_cmd,
    input  logic [psa_pkg::ID_W-1:0]        in_id,
    input  logic [psa_pkg::PRIO_BITS-1:0]   in_prio,
    input  logic                            in_defer,
    input  logic [psa_pkg::SLICE_W-1:0]     time_slice,
    input  logic                            out_free,
    output logic                            res_valid,
    output psa_pkg::psa_result_t            res,
    output logic                            mem_we,
    output logic [psa_pkg::ID_W-1:0]        mem_waddr,
    output psa_pkg::psa_entry_t             mem_wdata,
    output logic [psa_pkg::ID_W-1:0]        mem_raddr,
    input  psa_pkg::psa_entry_t             mem_rdata
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_INS_RD, ST_INS_CHK, ST_INS_WR_NEW, ST_INS_WR_PREV,
        ST_HD_RD, ST_HD_CHK, ST_AGE_RD, ST_AGE_CHK, ST_DQ_RD, ST_DQ_CHK, ST_DONE
    } state_t;

    state_t                              state_reg, state_next;
    logic [1:0]                          cmd_reg, cmd_next;
    logic [psa_pkg::ID_W-1:0]            ins_id_reg, ins_id_next;
    logic [psa_pkg::PRIO_BITS-1:0]       ins_key_reg, ins_key_next;
    logic [psa_pkg::PTR_W-1:0]           p_reg, p_next;
    logic [psa_pkg::PTR_W-1:0]           prev_reg, prev_next;
    logic [psa_pkg::PRIO_BITS-1:0]       prev_key_reg, prev_key_next;
    logic [psa_pkg::PRIO_BITS-1:0]       hk_reg, hk_next;
    logic                                all_reg, all_next;
    logic                                rs_ins_reg, rs_ins_next;
    logic                                below_reg, below_next;
    logic [psa_pkg::NUM_TASKS-1:0]       member_reg, member_next;
    logic [psa_pkg::ID_W-1:0]            head_reg, head_next;
    logic [psa_pkg::ID_W-1:0]            cur_reg, cur_next;
    logic [psa_pkg::PRIO_BITS-1:0]       cur_prio_reg, cur_prio_next;
    logic [psa_pkg::SLICE_W-1:0]         slice_reg, slice_next;
    logic [psa_pkg::ID_W-1:0]            raddr_reg;
    psa_pkg::psa_result_t                res_reg, res_next;
    psa_pkg::psa_entry_t                 rd;
    logic                                do_below;
    logic                                inc;
    logic                                new_run;

    // The idle entry is never written; it always reads as key zero at the tail.
    always_comb
    begin
        if (raddr_reg == '0)
        begin
            rd.key = '0;
            rd.nxt = psa_pkg::TAIL_MARK;
        end
        else
        begin
            rd = mem_rdata;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign res      = res_next;
    assign new_run  = res_valid && res.switched && (res.running_task != '0);
    assign inc      = (rd.key < psa_pkg::KEY_MAX) &&
                      (all_reg || ((rd.key < cur_prio_reg) && (rd.key < hk_reg)));

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        ins_id_next   = ins_id_reg;
        ins_key_next  = ins_key_reg;
        p_next        = p_reg;
        prev_next     = prev_reg;
        prev_key_next = prev_key_reg;
        hk_next       = hk_reg;
        all_next      = all_reg;
        rs_ins_next   = rs_ins_reg;
        below_next    = below_reg;
        member_next   = member_reg;
        head_next     = head_reg;
        cur_next      = cur_reg;
        cur_prio_next = cur_prio_reg;
        slice_next    = slice_reg;
        res_next      = res_reg;
        mem_we        = 1'b0;
        mem_waddr     = ins_id_reg;
        mem_wdata     = '{key: ins_key_reg, nxt: p_reg};
        mem_raddr     = p_reg[psa_pkg::ID_W-1:0];
        res_valid     = 1'b0;
        do_below      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_next     = '0;
                    cmd_next     = in_cmd;
                    below_next   = 1'b0;
                    rs_ins_next  = 1'b0;
                    ins_id_next  = in_id;
                    ins_key_next = (in_prio == '0) ? psa_pkg::PRIO_BITS'(1) : in_prio;
                    p_next       = psa_pkg::PTR_W'(head_reg);
                    prev_next    = psa_pkg::TAIL_MARK;
                    if (in_cmd == psa_pkg::CMD_ENQUEUE)
                    begin
                        if (in_id == '0 || member_reg[in_id])
                        begin
                            res_next.enqueue_rejected = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_INS_RD;
                        end
                    end
                    else if (in_cmd == psa_pkg::CMD_TICK)
                    begin
                        if (slice_reg != '0)
                        begin
                            slice_next = slice_reg - 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    else if (in_defer)
                    begin
                        res_next.deferred_attempt = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_HD_RD;
                    end
                end
            end
            ST_INS_RD:
            begin
                state_next = (p_reg == psa_pkg::TAIL_MARK) ? ST_INS_WR_NEW : ST_INS_CHK;
            end
            ST_INS_CHK:
            begin
                if (rd.key < ins_key_reg)
                begin
                    state_next = ST_INS_WR_NEW;
                end
                else
                begin
                    prev_next     = p_reg;
                    prev_key_next = rd.key;
                    p_next        = rd.nxt;
                    state_next    = ST_INS_RD;
                end
            end
            ST_INS_WR_NEW:
            begin
                mem_we                  = 1'b1;
                member_next[ins_id_reg] = 1'b1;
                if (prev_reg == psa_pkg::TAIL_MARK)
                begin
                    head_next  = ins_id_reg;
                    below_next = 1'b1;
                    state_next = rs_ins_reg ? ST_HD_RD : ST_DONE;
                end
                else
                begin
                    state_next = ST_INS_WR_PREV;
                end
            end
            ST_INS_WR_PREV:
            begin
                mem_we     = 1'b1;
                mem_waddr  = prev_reg[psa_pkg::ID_W-1:0];
                mem_wdata  = '{key: prev_key_reg, nxt: psa_pkg::PTR_W'(ins_id_reg)};
                below_next = 1'b1;
                state_next = rs_ins_reg ? ST_HD_RD : ST_DONE;
            end
            ST_HD_RD:
            begin
                mem_raddr  = head_reg;
                state_next = ST_HD_CHK;
            end
            ST_HD_CHK:
            begin
                hk_next = rd.key;
                if (below_reg)
                begin
                    do_below = 1'b1;
                end
                else if (cmd_reg == psa_pkg::CMD_RUN && cur_prio_reg > rd.key)
                begin
                    if (slice_reg == '0)
                    begin
                        all_next   = 1'b1;
                        p_next     = psa_pkg::PTR_W'(head_reg);
                        state_next = ST_AGE_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (cmd_reg == psa_pkg::CMD_RUN && cur_reg != '0 && !member_reg[cur_reg])
                begin
                    rs_ins_next  = 1'b1;
                    ins_id_next  = cur_reg;
                    ins_key_next = (cur_prio_reg == '0) ? psa_pkg::PRIO_BITS'(1)
                                                        : cur_prio_reg;
                    p_next       = psa_pkg::PTR_W'(head_reg);
                    prev_next    = psa_pkg::TAIL_MARK;
                    state_next   = ST_INS_RD;
                end
                else
                begin
                    do_below = 1'b1;
                end
                if (do_below)
                begin
                    all_next   = 1'b0;
                    p_next     = rd.nxt;
                    state_next = (head_reg == '0) ? ST_DQ_RD : ST_AGE_RD;
                end
            end
            ST_AGE_RD:
            begin
                if (p_reg == psa_pkg::TAIL_MARK || p_reg == '0)
                begin
                    if (all_reg)
                    begin
                        slice_next = time_slice;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DQ_RD;
                    end
                end
                else
                begin
                    state_next = ST_AGE_CHK;
                end
            end
            ST_AGE_CHK:
            begin
                if (inc)
                begin
                    mem_we              = 1'b1;
                    mem_waddr           = p_reg[psa_pkg::ID_W-1:0];
                    mem_wdata           = '{key: rd.key + 1'b1, nxt: rd.nxt};
                    res_next.aged_count = res_reg.aged_count + 1'b1;
                end
                p_next     = rd.nxt;
                state_next = ST_AGE_RD;
            end
            ST_DQ_RD:
            begin
                mem_raddr  = head_reg;
                state_next = ST_DQ_CHK;
            end
            ST_DQ_CHK:
            begin
                cur_next      = head_reg;
                cur_prio_next = rd.key;
                if (head_reg != '0)
                begin
                    head_next             = rd.nxt[psa_pkg::ID_W-1:0];
                    member_next[head_reg] = 1'b0;
                end
                slice_next        = time_slice;
                res_next.switched = 1'b1;
                state_next        = ST_DONE;
            end
            ST_DONE:
            begin
                res_next.running_task     = cur_reg;
                res_next.running_priority = cur_prio_reg;
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            member_reg   <= psa_pkg::NUM_TASKS'(1);
            head_reg     <= '0;
            cur_reg      <= '0;
            cur_prio_reg <= '0;
            slice_reg    <= psa_pkg::SLICE_W'(2);
        end
        else
        begin
            state_reg    <= state_next;
            member_reg   <= member_next;
            head_reg     <= head_next;
            cur_reg      <= cur_next;
            cur_prio_reg <= cur_prio_next;
            slice_reg    <= slice_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        ins_id_reg   <= ins_id_next;
        ins_key_reg  <= ins_key_next;
        p_reg        <= p_next;
        prev_reg     <= prev_next;
        prev_key_reg <= prev_key_next;
        hk_reg       <= hk_next;
        all_reg      <= all_next;
        rs_ins_reg   <= rs_ins_next;
        below_reg    <= below_next;
        res_reg      <= res_next;
        raddr_reg    <= mem_raddr;
    end

`include "priority_scheduler_with_aging_unit_assert.svh"

    `PSA_ASSERT_ALWAYS(a_idle_member, (!rst_n || member_reg[0]), "idle task left the ready list")
    `PSA_ASSERT(a_accept_leaves_idle, (in_valid && in_ready) |=> !in_ready, "accept kept idle")
    `PSA_ASSERT(a_switch_not_ready, new_run |-> !member_reg[cur_reg], "task still ready")

endmodule

// File: hdl/priority_scheduler_with_aging_unit.sv
// Top level of the priority scheduler with aging.
//
//  Channel   Dir  Payload
//  s_axis    in   tdata: task_id, task_priority, deferred; tuser: command
//  m_axis    out  tdata: running_task .. enqueue_rejected
//  cfg       in   cfg_data: time_slice
//
// A tick, a rejected enqueue or a deferred reschedule goes from idle straight to done.
// An enqueue reads and checks each list entry passed, then writes the new entry
// and, unless it becomes the head, the entry before it. A reschedule walks the
// list for insertion and aging one entry at a time, over the single memory read port.
// Reset needs no clearing pass; the output register lets a new item start
// while the previous result waits on m_axis_tready.
module priority_scheduler_with_aging_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // task_id[3:0], task_priority[11:4], deferred[12]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // running_task[3:0], running_priority[11:4],
                                        // switched[12], deferred_attempt[13],
                                        // aged_count[17:14], enqueue_rejected[18]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic [psa_pkg::SLICE_W-1:0] time_slice_reg;
    logic                        out_valid_reg;
    psa_pkg::psa_result_t        out_reg;
    logic                        out_free;
    logic                        res_valid;
    psa_pkg::psa_result_t        res;
    logic                        mem_we;
    logic [psa_pkg::ID_W-1:0]    mem_waddr;
    logic [psa_pkg::ID_W-1:0]    mem_raddr;
    psa_pkg::psa_entry_t         mem_wdata;
    psa_pkg::psa_entry_t         mem_rdata;

    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_slice_reg <= psa_pkg::SLICE_W'(2);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                time_slice_reg <= cfg_data;
            end
            if (res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    psa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tuser),
        .in_id      (s_axis_tdata[3:0]),
        .in_prio    (s_axis_tdata[11:4]),
        .in_defer   (s_axis_tdata[12]),
        .time_slice (time_slice_reg),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    psa_ram #(
        .DEPTH (psa_pkg::NUM_TASKS),
        .WIDTH (psa_pkg::ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the priority scheduler with aging.
module tb;

    typedef struct packed {
        logic [3:0]         task_id;
        logic [7:0]         prio;
        logic               defer;
        psa_pkg::psa_cmd_t  cmd;
    } sched_item_t;

    typedef struct packed {
        logic       rejected;
        logic [3:0] aged;
        logic       attempt;
        logic       switched;
        logic [7:0] run_prio;
        logic [3:0] run_task;
    } sched_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    priority_scheduler_with_aging_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Predictor state of the scheduler.
    logic [7:0] key_q [psa_pkg::NUM_TASKS];
    int         link_q [psa_pkg::NUM_TASKS];
    bit         queued [psa_pkg::NUM_TASKS];
    int         head_q;
    logic [3:0] cur_task;
    logic [7:0] cur_prio;
    logic [7:0] slice_q;
    logic [7:0] slice_len;

    sched_result_t pending_results[$];
    int  error_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;
    bit  fill_test;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic void sched_reset();
        for (int i = 0; i < psa_pkg::NUM_TASKS; i++)
        begin
            key_q[i] = 0;
            link_q[i] = psa_pkg::NUM_TASKS;
            queued[i] = 0;
        end
        queued[0] = 1;
        head_q = 0;
        cur_task = 0;
        cur_prio = 0;
        slice_q = 2;
        slice_len = 2;
    endfunction

    function automatic void ready_insert(int id, logic [7:0] k);
        int prev;
        int p;
        prev = psa_pkg::NUM_TASKS;
        p = head_q;
        for (int n = 0; n < psa_pkg::NUM_TASKS && p < psa_pkg::NUM_TASKS; n++)
        begin
            if (key_q[p] < k)
                break;
            prev = p;
            p = link_q[p];
        end
        key_q[id] = k;
        link_q[id] = p;
        queued[id] = 1;
        if (prev >= psa_pkg::NUM_TASKS)
            head_q = id;
        else
            link_q[prev] = id;
    endfunction

    function automatic int age_every();
        int p;
        int cnt;
        p = head_q;
        cnt = 0;
        for (int n = 0; n < psa_pkg::NUM_TASKS && p < psa_pkg::NUM_TASKS && p != 0; n++)
        begin
            if (key_q[p] < psa_pkg::KEY_MAX)
            begin
                key_q[p]++;
                cnt++;
            end
            p = link_q[p];
        end
        return cnt;
    endfunction

    function automatic int age_lower(logic [7:0] bound);
        int p;
        int cnt;
        logic [7:0] hk;
        cnt = 0;
        if (head_q >= psa_pkg::NUM_TASKS || head_q == 0)
            return 0;
        hk = key_q[head_q];
        p = link_q[head_q];
        for (int n = 0; n < psa_pkg::NUM_TASKS && p < psa_pkg::NUM_TASKS && p != 0; n++)
        begin
            if (key_q[p] < bound && key_q[p] < hk && key_q[p] < psa_pkg::KEY_MAX)
            begin
                key_q[p]++;
                cnt++;
            end
            p = link_q[p];
        end
        return cnt;
    endfunction

    function automatic sched_result_t schedule_step(sched_item_t it);
        sched_result_t r;
        int h;
        int nt;
        r = '0;
        if (it.cmd == psa_pkg::CMD_ENQUEUE)
        begin
            if (it.task_id == 0 || queued[it.task_id])
                r.rejected = 1;
            else
                ready_insert(it.task_id, (it.prio == 0) ? 8'd1 : it.prio);
        end
        else if (it.cmd == psa_pkg::CMD_TICK)
        begin
            if (slice_q > 0)
                slice_q--;
        end
        else if (it.defer)
            r.attempt = 1;
        else
        begin
            h = (head_q < psa_pkg::NUM_TASKS) ? head_q : 0;
            if (it.cmd == psa_pkg::CMD_RUN && cur_prio > key_q[h])
            begin
                if (slice_q == 0)
                begin
                    r.aged = 4'(age_every());
                    slice_q = slice_len;
                end
            end
            else
            begin
                if (it.cmd == psa_pkg::CMD_RUN && cur_task != 0 && !queued[cur_task])
                    ready_insert(cur_task, (cur_prio != 0) ? cur_prio : 8'd1);
                r.aged = 4'(age_lower(cur_prio));
                nt = (head_q < psa_pkg::NUM_TASKS) ? head_q : 0;
                if (nt != 0)
                begin
                    head_q = link_q[nt];
                    queued[nt] = 0;
                end
                cur_task = 4'(nt);
                cur_prio = key_q[nt];
                slice_q = slice_len;
                r.switched = 1;
            end
        end
        r.run_task = cur_task;
        r.run_prio = cur_prio;
        return r;
    endfunction

    task automatic send_item(sched_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata <= {3'b000, it.defer, it.prio, it.task_id};
        s_axis_tuser <= it.cmd;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(schedule_step(it));
    endtask

    task automatic write_slice(logic [7:0] v);
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        slice_len = v;
    endtask

    function automatic sched_item_t random_item();
        sched_item_t it;
        int r;
        r = $urandom_range(99);
        it.task_id = 4'($urandom_range(15));
        it.prio = 8'($urandom);
        if ($urandom_range(9) == 0)
            it.prio = ($urandom_range(1) != 0) ? 8'd255 : 8'd254;
        it.defer = ($urandom_range(7) == 0);
        if (r < 40)
            it.cmd = psa_pkg::CMD_ENQUEUE;
        else if (r < 65)
            it.cmd = psa_pkg::CMD_TICK;
        else if (r < 90)
            it.cmd = psa_pkg::CMD_RUN;
        else
            it.cmd = psa_pkg::CMD_BLOCK;
        return it;
    endfunction

    // Receiver: random stall, plus a long hold-off when filling the block.
    initial
    begin
        sched_result_t got;
        sched_result_t want;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[18:0];
                if (pending_results.size() == 0)
                    report_mismatch("unexpected item", 1, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (got.run_task !== want.run_task)
                        report_mismatch("running_task", got.run_task, want.run_task);
                    if (got.run_prio !== want.run_prio)
                        report_mismatch("running_priority", got.run_prio, want.run_prio);
                    if (got.switched !== want.switched)
                        report_mismatch("switched", got.switched, want.switched);
                    if (got.attempt !== want.attempt)
                        report_mismatch("deferred_attempt", got.attempt, want.attempt);
                    if (got.aged !== want.aged)
                        report_mismatch("aged_count", got.aged, want.aged);
                    if (got.rejected !== want.rejected)
                        report_mismatch("enqueue_rejected", got.rejected, want.rejected);
                end
            end
            if (fill_test)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles++;
                if (hold_cycles >= 600)
                    fill_test = 0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        sched_item_t directed[$];
        sched_result_t known[$];
        int guard;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        fill_test = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        sched_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: id, priority, deferred, command; known result where obvious.
        directed = '{
            '{4'd0, 8'd5, 1'b0, psa_pkg::CMD_ENQUEUE}, '{4'd0, 8'd0, 1'b0, psa_pkg::CMD_TICK},
            '{4'd0, 8'd0, 1'b0, psa_pkg::CMD_RUN},     '{4'd3, 8'd0, 1'b0, psa_pkg::CMD_ENQUEUE},
            '{4'd15, 8'd255, 1'b0, psa_pkg::CMD_ENQUEUE},
            '{4'd15, 8'd7, 1'b0, psa_pkg::CMD_ENQUEUE},
            '{4'd7, 8'd255, 1'b0, psa_pkg::CMD_ENQUEUE},
            '{4'd8, 8'd1, 1'b0, psa_pkg::CMD_ENQUEUE},
            '{4'd0, 8'd0, 1'b1, psa_pkg::CMD_RUN},     '{4'd0, 8'd0, 1'b1, psa_pkg::CMD_BLOCK},
            '{4'd0, 8'd0, 1'b0, psa_pkg::CMD_RUN},     '{4'd0, 8'd0, 1'b0, psa_pkg::CMD_TICK},
            '{4'd0, 8'd0, 1'b0, psa_pkg::CMD_TICK},    '{4'd0, 8'd0, 1'b0, psa_pkg::CMD_TICK},
            '{4'd0, 8'd0, 1'b0, psa_pkg::CMD_RUN},     '{4'd15, 8'd9, 1'b0, psa_pkg::CMD_ENQUEUE},
            '{4'd0, 8'd0, 1'b0, psa_pkg::CMD_RUN},     '{4'd0, 8'd0, 1'b0, psa_pkg::CMD_BLOCK},
            '{4'd0, 8'd0, 1'b0, psa_pkg::CMD_BLOCK},   '{4'd0, 8'd0, 1'b0, psa_pkg::CMD_BLOCK},
            '{4'd0, 8'd0, 1'b0, psa_pkg::CMD_BLOCK},   '{4'd0, 8'd0, 1'b0, psa_pkg::CMD_BLOCK}
        };
        // First three rows: reject idle enqueue, tick, reschedule to idle.
        known = '{19'h40000, 19'h00000, 19'h01000};
        for (int i = 0; i < directed.size(); i++)
        begin
            if (i < known.size())
            begin
                void'(schedule_step(directed[i]));
                pending_results.push_back(known[i]);
                send_idle_pct = 0;
                s_axis_tdata <= {3'b000, directed[i].defer, directed[i].prio,
                                 directed[i].task_id};
                s_axis_tuser <= directed[i].cmd;
                s_axis_tvalid <= 1'b1;
                @(posedge clk);
                while (!s_axis_tready)
                    @(posedge clk);
            end
            else
                send_item(directed[i]);
        end

        write_slice(8'd255);
        for (int i = 0; i < 20; i++)
            send_item(random_item());
        write_slice(8'd0);
        for (int i = 0; i < 20; i++)
            send_item(random_item());
        write_slice(8'd1);

        fill_test = 1;
        for (int i = 0; i < 30; i++)
            send_item(random_item());

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 29 : 82) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 29 : 82) : 0;
            write_slice(8'($urandom_range(1, 6)));
            for (int i = 0; i < 240; i++)
            begin
                if (i % 40 == 0)
                    for (int t = 1; t < 16; t++)
                        send_item('{4'(t), 8'($urandom), 1'b0, psa_pkg::CMD_ENQUEUE});
                send_item(random_item());
            end
        end
        write_slice(8'd3);

        guard = 0;
        while (pending_results.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
